FILE: sv/coo_sort_pkg.sv
`default_nettype none

package coo_sort_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int MAX_DIM_DEF     = 256;

   localparam int IDX_W     = 9;
   localparam int VAL_W     = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [IDX_W-1:0] NUM_ROWS_RST   = IDX_W'(256);
   localparam logic [IDX_W-1:0] NUM_COLS_RST   = IDX_W'(256);
   localparam logic             ORDER_MODE_RST = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS   = 2'd0,
      CSR_NUM_COLS   = 2'd1,
      CSR_ORDER_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
      logic [VAL_W-1:0] value_bits;
      logic             last_entry;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
      logic [VAL_W-1:0] out_value;
      logic             out_last;
      logic             index_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLR,
      ST_SRC,
      ST_KEY,
      ST_BKT,
      ST_UPD,
      ST_PRE_RD,
      ST_PRE_WR,
      ST_ORD_RD,
      ST_ENT_RD,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLR,
      OP_SRC,
      OP_KEY,
      OP_BKT,
      OP_UPD,
      OP_PRE_RD,
      OP_PRE_WR,
      OP_ORD_RD,
      OP_ENT_RD,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;
      logic      pass;
      logic      scat;
      logic      idx_clr;
      logic      elem_inc;
      logic      bkt_inc;
      logic      run_clr;
      logic      batch_end;
   } dp_cmd_type;

   typedef struct packed {
      logic load_done;
      logic elem_last;
      logic bkt_last;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/coo_sort_ram.sv
`default_nettype none

module coo_sort_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/coo_sort_ctrl.sv
`default_nettype none

module coo_sort_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire coo_sort_pkg::dp_status_type status,
   output coo_sort_pkg::dp_cmd_type        cmd
);

   import coo_sort_pkg::*;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      scat_ff, scat_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
         scat_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         scat_ff  <= scat_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      scat_in  = scat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status.load_done) begin
               state_in = ST_CLR;
               pass_in  = 1'b0;
               scat_in  = 1'b0;
            end
         end
         ST_CLR: begin
            if (status.bkt_last) begin
               state_in = ST_SRC;
               scat_in  = 1'b0;
            end
         end
         ST_SRC:    state_in = ST_KEY;
         ST_KEY:    state_in = ST_BKT;
         ST_BKT:    state_in = ST_UPD;
         ST_UPD: begin
            if (!status.elem_last) begin
               state_in = ST_SRC;
            end else if (!scat_ff) begin
               state_in = ST_PRE_RD;
            end else if (!pass_ff) begin
               state_in = ST_CLR;
               pass_in  = 1'b1;
            end else begin
               state_in = ST_ORD_RD;
            end
         end
         ST_PRE_RD: state_in = ST_PRE_WR;
         ST_PRE_WR: begin
            if (status.bkt_last) begin
               state_in = ST_SRC;
               scat_in  = 1'b1;
            end else begin
               state_in = ST_PRE_RD;
            end
         end
         ST_ORD_RD: state_in = ST_ENT_RD;
         ST_ENT_RD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.elem_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ORD_RD;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.op        = OP_NONE;
      cmd.pass      = pass_ff;
      cmd.scat      = scat_ff;
      cmd.load      = accept;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idx_clr = accept && status.load_done;
         end
         ST_CLR: begin
            cmd.op      = OP_CLR;
            cmd.idx_clr = status.bkt_last;
            cmd.bkt_inc = !status.bkt_last;
         end
         ST_SRC:    cmd.op = OP_SRC;
         ST_KEY:    cmd.op = OP_KEY;
         ST_BKT:    cmd.op = OP_BKT;
         ST_UPD: begin
            cmd.op       = OP_UPD;
            cmd.idx_clr  = status.elem_last;
            cmd.run_clr  = status.elem_last && !scat_ff;
            cmd.elem_inc = !status.elem_last;
         end
         ST_PRE_RD: cmd.op = OP_PRE_RD;
         ST_PRE_WR: begin
            cmd.op      = OP_PRE_WR;
            cmd.idx_clr = status.bkt_last;
            cmd.bkt_inc = !status.bkt_last;
         end
         ST_ORD_RD: cmd.op = OP_ORD_RD;
         ST_ENT_RD: cmd.op = OP_ENT_RD;
         ST_EMIT: begin
            cmd.op        = OP_EMIT;
            cmd.idx_clr   = status.elem_last;
            cmd.batch_end = status.elem_last;
            cmd.elem_inc  = !status.elem_last;
         end
         default:   cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/coo_sort_dp.sv
`default_nettype none

module coo_sort_dp #(
   parameter int MAX_ENTRIES = coo_sort_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_DIM     = coo_sort_pkg::MAX_DIM_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire coo_sort_pkg::dp_cmd_type              cmd,
   output coo_sort_pkg::dp_status_type                status,
   input  wire coo_sort_pkg::req_type                 req_data,
   output logic                                       rsp_valid,
   output coo_sort_pkg::rsp_type                      rsp_data,
   input  wire logic                                  csr_valid,
   input  wire logic [coo_sort_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [coo_sort_pkg::IDX_W-1:0]        csr_data
);

   import coo_sort_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IW    = $clog2(MAX_ENTRIES);
   localparam int KW    = $clog2(MAX_DIM);
   localparam int BND_W = (KW + 1 > IDX_W) ? KW + 1 : IDX_W;
   localparam int ENT_W = 2 * IDX_W + VAL_W;

   logic [IDX_W-1:0] rows_ff, cols_ff;
   logic             mode_ff;
   logic [CNT_W-1:0] cnt_ff, i_ff, run_ff;
   logic             err_ff;
   logic [KW-1:0]    j_ff, key_ff;
   logic [IW-1:0]    src_ff;

   logic [KW-1:0]    lim_r, lim_c, lim_sel;
   logic [KW-1:0]    row_key, col_key, key_now;
   logic             row_bad, col_bad, full, by_col;
   logic [IW-1:0]    src_now;

   logic             ent_we, skey_we, bkt_we, tmp_we, ord_we;
   logic [ENT_W-1:0] ent_rdata;
   logic [2*KW-1:0]  skey_rdata;
   logic [CNT_W-1:0] bkt_wdata, bkt_rdata;
   logic [KW-1:0]    bkt_waddr, bkt_raddr;
   logic [IW-1:0]    tmp_rdata, ord_rdata, dst_addr;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= NUM_ROWS_RST;
         cols_ff <= NUM_COLS_RST;
         mode_ff <= ORDER_MODE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_ROWS:   rows_ff <= csr_data;
            CSR_NUM_COLS:   cols_ff <= csr_data;
            CSR_ORDER_MODE: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective bound minus one: zero acts as one, large values cap at MAX_DIM
   function automatic logic [KW-1:0] bound_lim(input logic [IDX_W-1:0] b);
      logic [KW-1:0] r;
      if (b == '0) begin
         r = '0;
      end else if (BND_W'(b) > BND_W'(MAX_DIM)) begin
         r = KW'(MAX_DIM - 1);
      end else begin
         r = KW'(b - IDX_W'(1));
      end
      return r;
   endfunction

   assign lim_r = bound_lim(rows_ff);
   assign lim_c = bound_lim(cols_ff);

   always_comb begin
      row_bad = (req_data.row_index == '0) ||
                (BND_W'(req_data.row_index) > (BND_W'(lim_r) + BND_W'(1)));
      col_bad = (req_data.col_index == '0) ||
                (BND_W'(req_data.col_index) > (BND_W'(lim_c) + BND_W'(1)));
      if (req_data.row_index == '0) begin
         row_key = '0;
      end else if (row_bad) begin
         row_key = lim_r;
      end else begin
         row_key = KW'(req_data.row_index - IDX_W'(1));
      end
      if (req_data.col_index == '0) begin
         col_key = '0;
      end else if (col_bad) begin
         col_key = lim_c;
      end else begin
         col_key = KW'(req_data.col_index - IDX_W'(1));
      end
   end

   assign full    = (cnt_ff == CNT_W'(MAX_ENTRIES));
   assign by_col  = !(cmd.pass ^ mode_ff);
   assign lim_sel = by_col ? lim_c : lim_r;

   assign status.load_done = req_data.last_entry || full;
   assign status.elem_last = (i_ff == CNT_W'(cnt_ff - CNT_W'(1)));
   assign status.bkt_last  = (j_ff == lim_sel);

   // first pass walks arrival order directly
   assign src_now = cmd.pass ? tmp_rdata : i_ff[IW-1:0];
   assign key_now = by_col ? skey_rdata[KW-1:0] : skey_rdata[2*KW-1:KW];

   assign ent_we  = cmd.load && !full;
   assign skey_we = ent_we;

   always_comb begin
      bkt_we    = 1'b0;
      bkt_wdata = '0;
      bkt_waddr = j_ff;
      case (cmd.op)
         OP_CLR: begin
            bkt_we = 1'b1;
         end
         OP_UPD: begin
            bkt_we    = 1'b1;
            bkt_waddr = key_ff;
            bkt_wdata = CNT_W'(bkt_rdata + CNT_W'(1));
         end
         OP_PRE_WR: begin
            bkt_we    = 1'b1;
            bkt_wdata = run_ff;
         end
         default: ;
      endcase
   end

   assign bkt_raddr = (cmd.op == OP_BKT) ? key_now : j_ff;
   assign dst_addr  = bkt_rdata[IW-1:0];
   assign tmp_we    = (cmd.op == OP_UPD) && cmd.scat && !cmd.pass;
   assign ord_we    = (cmd.op == OP_UPD) && cmd.scat && cmd.pass;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         err_ff <= 1'b0;
         i_ff   <= '0;
         j_ff   <= '0;
         run_ff <= '0;
      end else begin
         if (cmd.batch_end) begin
            cnt_ff <= '0;
            err_ff <= 1'b0;
         end else if (cmd.load) begin
            if (full) begin
               err_ff <= 1'b1;
            end else begin
               cnt_ff <= CNT_W'(cnt_ff + CNT_W'(1));
               err_ff <= err_ff || row_bad || col_bad;
            end
         end
         if (cmd.idx_clr) begin
            i_ff <= '0;
            j_ff <= '0;
         end else begin
            if (cmd.elem_inc) begin
               i_ff <= CNT_W'(i_ff + CNT_W'(1));
            end
            if (cmd.bkt_inc) begin
               j_ff <= KW'(j_ff + KW'(1));
            end
         end
         if (cmd.run_clr) begin
            run_ff <= '0;
         end else if (cmd.op == OP_PRE_WR) begin
            run_ff <= CNT_W'(run_ff + bkt_rdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_KEY) begin
         src_ff <= src_now;
      end
      if (cmd.op == OP_BKT) begin
         key_ff <= key_now;
      end
   end

   coo_sort_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (cnt_ff[IW-1:0]),
      .wr_data ({req_data.row_index, req_data.col_index, req_data.value_bits}),
      .rd_addr (ord_rdata),
      .rd_data (ent_rdata)
   );

   coo_sort_ram #(.WIDTH(2 * KW), .DEPTH(MAX_ENTRIES)) u_skey_ram (
      .clock   (clock),
      .wr_en   (skey_we),
      .wr_addr (cnt_ff[IW-1:0]),
      .wr_data ({row_key, col_key}),
      .rd_addr (src_now),
      .rd_data (skey_rdata)
   );

   coo_sort_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM)) u_bkt_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_addr (bkt_raddr),
      .rd_data (bkt_rdata)
   );

   coo_sort_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_tmp_ram (
      .clock   (clock),
      .wr_en   (tmp_we),
      .wr_addr (dst_addr),
      .wr_data (src_ff),
      .rd_addr (i_ff[IW-1:0]),
      .rd_data (tmp_rdata)
   );

   coo_sort_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (dst_addr),
      .wr_data (src_ff),
      .rd_addr (i_ff[IW-1:0]),
      .rd_data (ord_rdata)
   );

   assign rsp_valid            = (cmd.op == OP_EMIT);
   assign rsp_data.out_row     = ent_rdata[ENT_W-1 -: IDX_W];
   assign rsp_data.out_col     = ent_rdata[VAL_W +: IDX_W];
   assign rsp_data.out_value   = ent_rdata[VAL_W-1:0];
   assign rsp_data.out_last    = status.elem_last;
   assign rsp_data.index_error = err_ff;

endmodule

`default_nettype wire

FILE: sv/coo_sparse_entry_sort_top.sv
`default_nettype none

// Sparse matrix entries (row, column, 64-bit value) load one per cycle
// while busy is low; the entry with last_entry set, or an entry that finds
// the store already holding MAX_ENTRIES entries (that one is dropped), ends
// the load. The block then raises busy and runs two stable counting passes
// over a bucket memory of MAX_DIM words, bounded by the configured row or
// column count B of each pass: per pass a clear sweep over B buckets, a count
// walk over the entries, a prefix sweep over B buckets and a scatter walk
// over the entries. Each of the n sorted entries then appears on rsp_data
// for one cycle with rsp_valid; busy falls after the last one. The receiver
// cannot stall results; it must take each one in the cycle it is shown.
// Configuration writes are always taken and belong between batches.
module coo_sparse_entry_sort_top #(
   parameter int MAX_ENTRIES = coo_sort_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_DIM     = coo_sort_pkg::MAX_DIM_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire coo_sort_pkg::req_type              req_data,
   output logic                                    rsp_valid,
   output coo_sort_pkg::rsp_type                   rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [coo_sort_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [coo_sort_pkg::IDX_W-1:0]     csr_data
);

   import coo_sort_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   coo_sort_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   coo_sort_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIM     (MAX_DIM)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
module tb_top;
   import coo_sort_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE      = 16;
   localparam int TAIL        = 3000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    busy;
   req_type req_data  = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NUM_ROWS;
   logic [IDX_W-1:0]     csr_data  = '0;

   coo_sparse_entry_sort_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // requests waiting to go out, sorted results still to come
   req_type entry_queue[$];
   rsp_type sorted_due[$];

   // mirror of the block: registers and the batch being loaded
   logic [IDX_W-1:0] cfg_rows      = NUM_ROWS_RST;
   logic [IDX_W-1:0] cfg_cols      = NUM_COLS_RST;
   logic             cfg_col_major = ORDER_MODE_RST;
   req_type    held_entries[$];
   logic [7:0] row_keys[$];
   logic [7:0] col_keys[$];
   logic       batch_bad = 1'b0;

   int sender_idle   = 37;
   int mismatches    = 0;
   int entries_seen  = 0;
   int batches_done  = 0;
   int bad_batches   = 0;
   int full_batches  = 0;
   int results_seen  = 0;
   int quiet_cycles  = 0;

   // zero-based ordering key; the bound register saturates to [1, MAX_DIM]
   function automatic logic [7:0] clamp_key(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] bound_reg,
                                            inout logic bad);
      int b;
      b = (bound_reg == 0) ? 1 : ((bound_reg > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(bound_reg));
      if (idx == 0) begin
         bad = 1'b1;
         return 8'd0;
      end
      if (int'(idx) > b) begin
         bad = 1'b1;
         return 8'(b - 1);
      end
      return 8'(idx - 1);
   endfunction

   function automatic logic [15:0] order_key(int i);
      return cfg_col_major ? {col_keys[i], row_keys[i]} : {row_keys[i], col_keys[i]};
   endfunction

   function automatic void emit_sorted();
      int      order[$];
      int      n;
      int      j;
      int      t;
      rsp_type r;
      n = held_entries.size();
      for (int i = 0; i < n; i++) order.insert(order.size(), i);
      // stable insertion sort, equal keys keep arrival order
      for (int i = 1; i < n; i++) begin
         j = i;
         while (j > 0 && order_key(order[j-1]) > order_key(order[j])) begin
            t = order[j];
            order[j] = order[j-1];
            order[j-1] = t;
            j--;
         end
      end
      for (int i = 0; i < n; i++) begin
         r.out_row     = held_entries[order[i]].row_index;
         r.out_col     = held_entries[order[i]].col_index;
         r.out_value   = held_entries[order[i]].value_bits;
         r.out_last    = (i == n - 1);
         r.index_error = batch_bad;
         sorted_due.insert(sorted_due.size(), r);
      end
      batches_done++;
      if (batch_bad) bad_batches++;
      held_entries.delete();
      row_keys.delete();
      col_keys.delete();
      batch_bad = 1'b0;
   endfunction

   function automatic void load_entry(req_type e);
      logic bad;
      logic ends_load;
      bad = 1'b0;
      ends_load = e.last_entry;
      entries_seen++;
      if (held_entries.size() >= MAX_ENTRIES_DEF) begin
         // store full: entry dropped, load ends
         batch_bad = 1'b1;
         ends_load = 1'b1;
         full_batches++;
      end else begin
         row_keys.insert(row_keys.size(), clamp_key(e.row_index, cfg_rows, bad));
         col_keys.insert(col_keys.size(), clamp_key(e.col_index, cfg_cols, bad));
         if (bad) batch_bad = 1'b1;
         held_entries.insert(held_entries.size(), e);
      end
      if (ends_load) emit_sorted();
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) load_entry(req_data);
         if (!start || !busy) begin
            if (entry_queue.size() > 0 && $urandom_range(99) >= sender_idle) begin
               req_data <= entry_queue.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void flag_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (sorted_due.size() == 0) begin
            $display("%0t: result with none due: expected nothing, actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            flag_field("out_row", sorted_due[0].out_row, rsp_data.out_row);
            flag_field("out_col", sorted_due[0].out_col, rsp_data.out_col);
            flag_field("out_value", sorted_due[0].out_value, rsp_data.out_value);
            flag_field("out_last", sorted_due[0].out_last, rsp_data.out_last);
            flag_field("index_error", sorted_due[0].index_error, rsp_data.index_error);
            void'(sorted_due.pop_front());
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [IDX_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NUM_ROWS:   cfg_rows = val;
         CSR_NUM_COLS:   cfg_cols = val;
         CSR_ORDER_MODE: cfg_col_major = val[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [IDX_W-1:0] rows, logic [IDX_W-1:0] cols, logic col_major);
      write_reg(CSR_NUM_ROWS, rows);
      write_reg(CSR_NUM_COLS, cols);
      write_reg(CSR_ORDER_MODE, {8'd0, col_major});
   endtask

   // hold the sender off until every due result is in and the block is idle
   task automatic drain();
      do @(negedge clock);
      while (entry_queue.size() != 0 || start || sorted_due.size() != 0 || busy);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void queue_entry(int r, int c, logic [63:0] v, logic lst);
      req_type e;
      e.row_index  = IDX_W'(r);
      e.col_index  = IDX_W'(c);
      e.value_bits = v;
      e.last_entry = lst;
      entry_queue.insert(entry_queue.size(), e);
   endfunction

   // mostly clean batches of random content, some stray indices and big loads
   task automatic queue_random(int count, int rb, int cb, bit with_overflow);
      int          made;
      int          size;
      int          r;
      int          c;
      logic [63:0] v;
      logic        lst;
      made = 0;
      while (made < count) begin
         if (with_overflow) begin
            size = MAX_ENTRIES_DEF + 1;
            with_overflow = 1'b0;
         end else if ($urandom_range(99) < 15) begin
            size = $urandom_range(16, MAX_ENTRIES_DEF);
         end else begin
            size = $urandom_range(1, 8);
         end
         for (int k = 0; k < size; k++) begin
            if ($urandom_range(99) < 4) begin
               r = $urandom_range(511);
               c = $urandom_range(511);
            end else begin
               r = $urandom_range(rb, 1);
               c = $urandom_range(cb, 1);
            end
            case ($urandom_range(9))
               0:       v = '0;
               1:       v = '1;
               default: v = {$urandom, $urandom};
            endcase
            // the dropped entry of a full load may carry last or not
            if (size > MAX_ENTRIES_DEF) lst = (k == size - 1) ? 1'($urandom) : 1'b0;
            else lst = (k == size - 1);
            queue_entry(r, c, v, lst);
         end
         made += size;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes of indices and values, duplicate keys
      sender_idle = 37;
      queue_entry(256, 256, '1, 1'b1);
      queue_entry(3, 7, '0, 1'b0);
      queue_entry(1, 256, '1, 1'b0);
      queue_entry(3, 2, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
      queue_entry(1, 1, 64'h8000_0000_0000_0001, 1'b0);
      queue_entry(3, 7, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
      queue_entry(256, 1, 64'h0123_4567_89AB_CDEF, 1'b1);
      // zero and oversized indices
      queue_entry(0, 5, 64'h1, 1'b0);
      queue_entry(300, 0, 64'h2, 1'b0);
      queue_entry(511, 511, 64'h3, 1'b0);
      queue_entry(2, 257, 64'h4, 1'b1);
      drain();

      // zero and oversized bounds, column-major
      configure(9'd0, 9'd511, 1'b1);
      queue_entry(1, 3, 64'h10, 1'b0);
      queue_entry(1, 256, 64'h11, 1'b0);
      queue_entry(1, 1, 64'h12, 1'b0);
      queue_entry(1, 3, 64'h13, 1'b1);
      queue_entry(1, 9, 64'h20, 1'b0);
      queue_entry(2, 3, 64'h21, 1'b0);
      queue_entry(1, 2, 64'h22, 1'b1);
      drain();

      configure(9'd8, 9'd5, 1'b0);
      queue_random(80, 8, 5, 1'b0);
      drain();

      sender_idle = 85;
      configure(9'd1, 9'd256, 1'b1);
      queue_random(80, 1, 256, 1'b0);
      drain();

      sender_idle = 0;
      configure(9'd256, 9'd3, 1'b0);
      queue_random(80, 256, 3, 1'b1);
      drain();
      write_reg(CSR_ORDER_MODE, 9'd1);
      queue_random(20, 256, 3, 1'b0);
      drain();

      repeat (TAIL) @(posedge clock);
      if (sorted_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, sorted_due.size());
         mismatches++;
      end
      $display("covered %0d entries in %0d batches, %0d sorted results checked",
               entries_seen, batches_done, results_seen);
      $display("%0d batches flagged bad, %0d ended on a full store, both order modes",
               bad_batches, full_batches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/coo_sort_pkg.sv
sv/coo_sort_ram.sv
sv/coo_sort_ctrl.sv
sv/coo_sort_dp.sv
sv/coo_sparse_entry_sort_top.sv
tb/sv/tb_top.sv
